// ----- sv/amc_pkg.sv -----
// Shared constants and codes for the multi-pattern string matcher.
package amc_pkg;

  // Table sizes
  localparam int unsigned MAX_NODES    = 1024;
  localparam int unsigned NODE_W       = $clog2(MAX_NODES);
  localparam int unsigned ALPHA_SIZE   = 256;
  localparam int unsigned ALPHA_W      = $clog2(ALPHA_SIZE);
  localparam int unsigned MAX_PATTERNS = 256;
  localparam int unsigned PAT_W        = $clog2(MAX_PATTERNS);
  localparam int unsigned COUNT_W      = 32;
  localparam int unsigned CHILD_AW     = NODE_W + ALPHA_W;
  localparam int unsigned LINK_W       = NODE_W + 1;

  // Port field widths
  localparam int unsigned OP_W   = 3;
  localparam int unsigned SYM_W  = 8;
  localparam int unsigned IDX_W  = 8;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned PID_W  = 8;
  localparam int unsigned OCC_W  = 32;
  localparam int unsigned HITS_W = 9;

  // Operation codes
  localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
  localparam logic [OP_W-1:0] OP_END    = 3'd1;
  localparam logic [OP_W-1:0] OP_BUILD  = 3'd2;
  localparam logic [OP_W-1:0] OP_SCAN   = 3'd3;
  localparam logic [OP_W-1:0] OP_READ   = 3'd4;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_NODE_FULL = 2'd1;
  localparam logic [ST_W-1:0] ST_PAT_FULL  = 2'd2;
  localparam logic [ST_W-1:0] ST_BAD       = 2'd3;

endpackage

// ----- sv/amc_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module amc_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 10,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/multi_pattern_string_matcher_core.sv -----
// Aho-Corasick matcher core: trie load, link build, scan and count read.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  command  | start / busy         | operation, symbol, pattern_index
//  result   | done (1-cycle pulse) | status, pattern_id, occurrences,
//           |                      | matches_here
//
// End pattern is answered from idle; append and read wait on registered reads;
// scan adds a failure-state visit per failure hop and a link-state visit per
// dictionary-link hop. Build is bound by the child table's one read port (one
// symbol probe per cycle, held in failure walks). After reset, with busy high,
// the child table and node tables are swept to zero, one entry a cycle. One
// word is in flight at a time; done pulses once per word and cannot be stalled.
module multi_pattern_string_matcher_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [amc_pkg::OP_W-1:0]   operation,
  input  logic [amc_pkg::SYM_W-1:0]  symbol,
  input  logic [amc_pkg::IDX_W-1:0]  pattern_index,
  output logic                       done,
  output logic [amc_pkg::ST_W-1:0]   status,
  output logic [amc_pkg::PID_W-1:0]  pattern_id,
  output logic [amc_pkg::OCC_W-1:0]  occurrences,
  output logic [amc_pkg::HITS_W-1:0] matches_here
);
  import amc_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_APPEND_W, S_READ_PW, S_READ_CW,
    S_SCAN_CW, S_SCAN_FW, S_SCAN_TW, S_SCAN_LW,
    S_B_POP, S_B_VW, S_B_CW, S_B_FW, S_B_FCW, S_B_OW
  } state_t;

  localparam logic [NODE_W:0]  NODES_MAX = (NODE_W+1)'(MAX_NODES);
  localparam logic [PAT_W:0]   PATS_MAX  = (PAT_W+1)'(MAX_PATTERNS);
  localparam logic [ALPHA_W-1:0] SYM_LAST = ALPHA_W'(ALPHA_SIZE - 1);
  localparam logic [HITS_W-1:0] HITS_MAX = '1;

  state_t state;
  logic [CHILD_AW-1:0] clr_addr;
  logic [NODE_W:0]     nodes_used;
  logic [PAT_W:0]      patterns_used;
  logic [NODE_W-1:0]   insert_node, scan_node;
  logic                built;
  logic [ALPHA_W-1:0]  sq;
  logic [NODE_W-1:0]   cur, v, u;
  logic [ALPHA_W-1:0]  a;
  logic [NODE_W:0]     head, tail;
  logic [HITS_W-1:0]   hits;

  // memory ports
  logic                child_we;
  logic [CHILD_AW-1:0] child_waddr, child_raddr;
  logic [NODE_W-1:0]   child_wdata, child_rdata;
  logic                fail_we;
  logic [NODE_W-1:0]   fail_waddr, fail_raddr, fail_wdata, fail_rdata;
  logic                olink_we;
  logic [NODE_W-1:0]   olink_waddr, olink_raddr;
  logic [LINK_W-1:0]   olink_wdata, olink_rdata;
  logic                term_we;
  logic [NODE_W-1:0]   term_waddr, term_raddr;
  logic                term_wdata, term_rdata;
  logic                cnt_we;
  logic [NODE_W-1:0]   cnt_waddr, cnt_raddr;
  logic [COUNT_W-1:0]  cnt_wdata, cnt_rdata, cnt_inc;
  logic                pend_we;
  logic [PAT_W-1:0]    pend_waddr, pend_raddr;
  logic [NODE_W-1:0]   pend_wdata, pend_rdata;
  logic                q_we;
  logic [NODE_W-1:0]   q_waddr, q_raddr, q_wdata, q_rdata;

  logic accept;
  logic [NODE_W-1:0] link_idx;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign cnt_inc  = (cnt_rdata == '1) ? cnt_rdata : cnt_rdata + 1'b1;
  assign link_idx = olink_rdata[NODE_W-1:0];

  amc_ram #(.DEPTH(MAX_NODES*ALPHA_SIZE), .WIDTH(NODE_W)) u_child (
    .clk, .we(child_we), .waddr(child_waddr), .wdata(child_wdata),
    .raddr(child_raddr), .rdata(child_rdata));
  amc_ram #(.DEPTH(MAX_NODES), .WIDTH(NODE_W)) u_fail (
    .clk, .we(fail_we), .waddr(fail_waddr), .wdata(fail_wdata),
    .raddr(fail_raddr), .rdata(fail_rdata));
  amc_ram #(.DEPTH(MAX_NODES), .WIDTH(LINK_W)) u_olink (
    .clk, .we(olink_we), .waddr(olink_waddr), .wdata(olink_wdata),
    .raddr(olink_raddr), .rdata(olink_rdata));
  amc_ram #(.DEPTH(MAX_NODES), .WIDTH(1)) u_term (
    .clk, .we(term_we), .waddr(term_waddr), .wdata(term_wdata),
    .raddr(term_raddr), .rdata(term_rdata));
  amc_ram #(.DEPTH(MAX_NODES), .WIDTH(COUNT_W)) u_cnt (
    .clk, .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rdata));
  amc_ram #(.DEPTH(MAX_PATTERNS), .WIDTH(NODE_W)) u_pend (
    .clk, .we(pend_we), .waddr(pend_waddr), .wdata(pend_wdata),
    .raddr(pend_raddr), .rdata(pend_rdata));
  amc_ram #(.DEPTH(MAX_NODES), .WIDTH(NODE_W)) u_queue (
    .clk, .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata));

  // Memory address and write control per state
  always_comb begin
    child_we = 1'b0; child_waddr = '0; child_wdata = '0; child_raddr = '0;
    fail_we = 1'b0; fail_waddr = '0; fail_wdata = '0; fail_raddr = '0;
    olink_we = 1'b0; olink_waddr = '0; olink_wdata = '0; olink_raddr = '0;
    term_we = 1'b0; term_waddr = '0; term_wdata = 1'b0; term_raddr = '0;
    cnt_we = 1'b0; cnt_waddr = '0; cnt_wdata = '0; cnt_raddr = '0;
    pend_we = 1'b0; pend_waddr = '0; pend_wdata = '0; pend_raddr = '0;
    q_we = 1'b0; q_waddr = '0; q_wdata = '0; q_raddr = '0;
    case (state)
      S_CLEAR: begin
        child_we = 1'b1; child_waddr = clr_addr;
        fail_we  = 1'b1; fail_waddr  = clr_addr[NODE_W-1:0];
        olink_we = 1'b1; olink_waddr = clr_addr[NODE_W-1:0];
        term_we  = 1'b1; term_waddr  = clr_addr[NODE_W-1:0];
        cnt_we   = 1'b1; cnt_waddr   = clr_addr[NODE_W-1:0];
      end
      S_IDLE: begin
        if (accept) begin
          case (operation)
            OP_APPEND: child_raddr = {insert_node, symbol};
            OP_SCAN:   child_raddr = {scan_node, symbol};
            OP_READ:   pend_raddr  = pattern_index;
            OP_END: begin
              if (!built && patterns_used < PATS_MAX) begin
                term_we = 1'b1; term_waddr = insert_node; term_wdata = 1'b1;
                pend_we = 1'b1; pend_waddr = patterns_used[PAT_W-1:0];
                pend_wdata = insert_node;
              end
            end
            OP_BUILD: begin
              q_we = !built; q_waddr = '0; q_wdata = '0;
            end
            default: ;
          endcase
        end
      end
      S_APPEND_W: begin
        if (child_rdata == '0 && nodes_used < NODES_MAX) begin
          child_we = 1'b1; child_waddr = {insert_node, sq};
          child_wdata = nodes_used[NODE_W-1:0];
        end
      end
      S_READ_PW: cnt_raddr = pend_rdata;
      S_SCAN_CW: begin
        if (child_rdata == '0 && cur != '0) begin
          fail_raddr = cur;
        end else begin
          term_raddr = child_rdata; olink_raddr = child_rdata;
          cnt_raddr = child_rdata;
        end
      end
      S_SCAN_FW: child_raddr = {fail_rdata, sq};
      S_SCAN_TW, S_SCAN_LW: begin
        // bump the current node when it matches, then follow the dictionary link
        cnt_we = (state == S_SCAN_LW) || term_rdata;
        cnt_waddr = cur; cnt_wdata = cnt_inc;
        olink_raddr = link_idx; cnt_raddr = link_idx;
      end
      S_B_POP: q_raddr = head[NODE_W-1:0];
      S_B_VW:  child_raddr = {q_rdata, {ALPHA_W{1'b0}}};
      S_B_CW: begin
        if (child_rdata == '0) begin
          child_raddr = {v, a + 1'b1};
        end else if (v == '0) begin
          fail_we = 1'b1; fail_waddr = child_rdata; fail_wdata = '0;
          term_raddr = '0; olink_raddr = '0;
        end else begin
          fail_raddr = v;
        end
      end
      S_B_FW: child_raddr = {fail_rdata, a};
      S_B_FCW: begin
        if (cur != '0 && child_rdata == '0) begin
          fail_raddr = cur;
        end else begin
          fail_we = 1'b1; fail_waddr = u; fail_wdata = child_rdata;
          term_raddr = child_rdata; olink_raddr = child_rdata;
        end
      end
      S_B_OW: begin
        olink_we = 1'b1; olink_waddr = u;
        olink_wdata = term_rdata ? {1'b1, cur} : olink_rdata;
        q_we = (tail < NODES_MAX); q_waddr = tail[NODE_W-1:0]; q_wdata = u;
        child_raddr = {v, a + 1'b1};
      end
      default: ;
    endcase
  end

  // Sequencer, architectural registers and result word
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= S_CLEAR; clr_addr <= '0;
      nodes_used <= (NODE_W+1)'(1); patterns_used <= '0;
      insert_node <= '0; scan_node <= '0; built <= 1'b0;
      head <= '0; tail <= '0; hits <= '0;
      status <= ST_OK; pattern_id <= '0; occurrences <= '0; matches_here <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            sq <= symbol;
            status <= ST_OK; pattern_id <= '0; occurrences <= '0;
            matches_here <= '0;
            case (operation)
              OP_APPEND: begin
                if (built) begin status <= ST_BAD; done <= 1'b1; end
                else state <= S_APPEND_W;
              end
              OP_END: begin
                done <= 1'b1;
                if (built) status <= ST_BAD;
                else if (patterns_used >= PATS_MAX) status <= ST_PAT_FULL;
                else begin
                  pattern_id <= patterns_used[PAT_W-1:0];
                  patterns_used <= patterns_used + 1'b1;
                  insert_node <= '0;
                end
              end
              OP_BUILD: begin
                if (built) begin status <= ST_BAD; done <= 1'b1; end
                else begin head <= '0; tail <= (NODE_W+1)'(1); state <= S_B_POP; end
              end
              OP_SCAN: begin
                if (!built) begin status <= ST_BAD; done <= 1'b1; end
                else begin cur <= scan_node; hits <= '0; state <= S_SCAN_CW; end
              end
              OP_READ: begin
                if ({1'b0, pattern_index} >= patterns_used) begin
                  status <= ST_BAD; done <= 1'b1;
                end else state <= S_READ_PW;
              end
              default: begin status <= ST_BAD; done <= 1'b1; end
            endcase
          end
        end
        S_APPEND_W: begin
          done <= 1'b1; state <= S_IDLE;
          if (child_rdata != '0) insert_node <= child_rdata;
          else if (nodes_used >= NODES_MAX) status <= ST_NODE_FULL;
          else begin
            insert_node <= nodes_used[NODE_W-1:0];
            nodes_used <= nodes_used + 1'b1;
          end
        end
        S_READ_PW: state <= S_READ_CW;
        S_READ_CW: begin
          occurrences <= cnt_rdata; done <= 1'b1; state <= S_IDLE;
        end
        // scan: failure walk, then dictionary chain
        S_SCAN_CW: begin
          if (child_rdata == '0 && cur != '0) state <= S_SCAN_FW;
          else begin
            cur <= child_rdata; scan_node <= child_rdata; state <= S_SCAN_TW;
          end
        end
        S_SCAN_FW: begin cur <= fail_rdata; state <= S_SCAN_CW; end
        S_SCAN_TW, S_SCAN_LW: begin
          logic [HITS_W-1:0] h;
          h = hits;
          if ((state == S_SCAN_LW || term_rdata) && hits != HITS_MAX) h = hits + 1'b1;
          hits <= h;
          if (olink_rdata[NODE_W]) begin
            cur <= link_idx; state <= S_SCAN_LW;
          end else begin
            matches_here <= h; done <= 1'b1; state <= S_IDLE;
          end
        end
        // build: breadth-first link computation
        S_B_POP: begin
          if (head == tail) begin
            built <= 1'b1; scan_node <= '0; done <= 1'b1; state <= S_IDLE;
          end else begin
            head <= head + 1'b1; state <= S_B_VW;
          end
        end
        S_B_VW: begin v <= q_rdata; a <= '0; state <= S_B_CW; end
        S_B_CW: begin
          if (child_rdata == '0) begin
            if (a == SYM_LAST) state <= S_B_POP;
            else a <= a + 1'b1;
          end else begin
            u <= child_rdata;
            if (v == '0) begin cur <= '0; state <= S_B_OW; end
            else state <= S_B_FW;
          end
        end
        S_B_FW: begin cur <= fail_rdata; state <= S_B_FCW; end
        S_B_FCW: begin
          if (cur != '0 && child_rdata == '0) state <= S_B_FW;
          else begin cur <= child_rdata; state <= S_B_OW; end
        end
        S_B_OW: begin
          if (tail < NODES_MAX) tail <= tail + 1'b1;
          if (a == SYM_LAST) state <= S_B_POP;
          else begin a <= a + 1'b1; state <= S_B_CW; end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_nodes_bound: assert property (@(posedge clk) disable iff (rst)
    nodes_used <= NODES_MAX && nodes_used != '0)
    else $error("node count out of range");
  a_queue_order: assert property (@(posedge clk) disable iff (rst)
    head <= tail && tail <= NODES_MAX)
    else $error("bfs queue pointers out of order");
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_OK |-> pattern_id == '0 && matches_here == '0)
    else $error("failed word carries payload");
  a_no_scan_unbuilt: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN_CW || state == S_SCAN_TW) |-> built)
    else $error("scan running before build");

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for the Aho-Corasick matcher core: load, build, scan and read.
module testbench;
  import amc_pkg::*;

  typedef struct packed {
    logic [ST_W-1:0]   st;
    logic [PID_W-1:0]  pid;
    logic [OCC_W-1:0]  occ;
    logic [HITS_W-1:0] hits;
  } answer_t;

  localparam logic [LINK_W-1:0] LINK_OK = LINK_W'(1) << NODE_W;
  localparam logic [COUNT_W-1:0] COUNT_TOP = '1;
  localparam logic [HITS_W-1:0] HITS_TOP = '1;

  logic clk, rst, start, busy, done;
  logic [OP_W-1:0]   operation;
  logic [SYM_W-1:0]  symbol;
  logic [IDX_W-1:0]  pattern_index;
  logic [ST_W-1:0]   status;
  logic [PID_W-1:0]  pattern_id;
  logic [OCC_W-1:0]  occurrences;
  logic [HITS_W-1:0] matches_here;

  multi_pattern_string_matcher_core DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .symbol(symbol), .pattern_index(pattern_index),
    .done(done), .status(status), .pattern_id(pattern_id),
    .occurrences(occurrences), .matches_here(matches_here)
  );

  // Automaton mirror
  logic [NODE_W-1:0]  kid [0:MAX_NODES*ALPHA_SIZE-1];
  logic [NODE_W-1:0]  fail_of [0:MAX_NODES-1];
  logic [LINK_W-1:0]  dict_of [0:MAX_NODES-1];
  bit                 term [0:MAX_NODES-1];
  logic [COUNT_W-1:0] hit_cnt [0:MAX_NODES-1];
  logic [NODE_W-1:0]  pat_node [0:MAX_PATTERNS-1];
  int unsigned        nodes_used, pats_used;
  logic [NODE_W-1:0]  ins_node, cur_node;
  bit                 built;

  answer_t pending[$];
  int      errors = 0;
  int      words_sent = 0;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic logic [NODE_W-1:0] child(logic [NODE_W-1:0] n, logic [SYM_W-1:0] s);
    return kid[{n, s}];
  endfunction

  // Breadth-first failure and dictionary links
  task automatic build_links();
    int bfs[$];
    int v, u, tail;
    logic [NODE_W-1:0] f;
    bfs.insert(bfs.size(), 0);
    tail = 1;
    while (bfs.size() > 0) begin
      v = bfs.pop_front();
      for (int a = 0; a < ALPHA_SIZE; a++) begin
        u = child(NODE_W'(v), SYM_W'(a));
        if (u == 0) continue;
        f = 0;
        if (v != 0) begin
          f = fail_of[v];
          while (f != 0 && child(f, SYM_W'(a)) == 0) f = fail_of[f];
          f = child(f, SYM_W'(a));
        end
        fail_of[u] = f;
        dict_of[u] = term[f] ? (LINK_OK | f) : dict_of[f];
        if (tail < MAX_NODES) begin
          bfs.insert(bfs.size(), u);
          tail++;
        end
      end
    end
  endtask

  function automatic void bump(int n);
    if (hit_cnt[n] != COUNT_TOP) hit_cnt[n]++;
  endfunction

  // Expected answer for one word, updating the mirror
  task automatic predict_word(logic [OP_W-1:0] op, logic [SYM_W-1:0] s,
                              logic [IDX_W-1:0] idx, output answer_t r);
    logic [NODE_W-1:0] n;
    logic [LINK_W-1:0] lk;
    int h;
    r = '0;
    h = 0;
    case (op)
      OP_APPEND: begin
        if (built) r.st = ST_BAD;
        else if (child(ins_node, s) != 0) ins_node = child(ins_node, s);
        else if (nodes_used >= MAX_NODES) r.st = ST_NODE_FULL;
        else begin
          kid[{ins_node, s}] = NODE_W'(nodes_used);
          ins_node = NODE_W'(nodes_used);
          nodes_used++;
        end
      end
      OP_END: begin
        if (built) r.st = ST_BAD;
        else if (pats_used >= MAX_PATTERNS) r.st = ST_PAT_FULL;
        else begin
          term[ins_node] = 1;
          pat_node[pats_used] = ins_node;
          r.pid = PID_W'(pats_used);
          pats_used++;
          ins_node = 0;
        end
      end
      OP_BUILD: begin
        if (built) r.st = ST_BAD;
        else begin
          build_links();
          built = 1;
          cur_node = 0;
        end
      end
      OP_SCAN: begin
        if (!built) r.st = ST_BAD;
        else begin
          n = cur_node;
          while (n != 0 && child(n, s) == 0) n = fail_of[n];
          n = child(n, s);
          cur_node = n;
          if (term[n]) begin
            bump(n);
            h++;
          end
          lk = dict_of[n];
          while (lk[NODE_W]) begin
            bump(lk[NODE_W-1:0]);
            h++;
            lk = dict_of[lk[NODE_W-1:0]];
          end
          r.hits = (h > HITS_TOP) ? HITS_TOP : HITS_W'(h);
        end
      end
      OP_READ: begin
        if (idx >= pats_used) r.st = ST_BAD;
        else r.occ = hit_cnt[pat_node[idx]];
      end
      default: r.st = ST_BAD;
    endcase
  endtask

  // Send one word and hold start high, then sometimes drop start for a random gap
  task automatic send_word(logic [OP_W-1:0] op, logic [SYM_W-1:0] s, logic [IDX_W-1:0] idx);
    answer_t r;
    start <= 1'b1;
    operation <= op;
    symbol <= s;
    pattern_index <= idx;
    do @(posedge clk); while (busy);
    predict_word(op, s, idx, r);
    pending.insert(pending.size(), r);
    words_sent++;
    // random gaps, none in one long stretch
    if (!(words_sent >= 700 && words_sent < 950) && $urandom_range(99) < 30) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic logic [SYM_W-1:0] text_byte();
    return ($urandom_range(99) < 80) ? SYM_W'(8'h61 + $urandom_range(3)) : SYM_W'($urandom);
  endfunction

  function automatic logic [OP_W-1:0] unused_op();
    return OP_READ + OP_W'($urandom_range(1, 3));
  endfunction

  function automatic logic [OP_W-1:0] OP_SSEL(int pick);
    return (pick < 96) ? OP_APPEND : (pick < 98) ? OP_END : OP_BUILD;
  endfunction

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    answer_t e;
    if (!rst && done) begin
      if (pending.size() == 0) begin
        $display("%0t: unexpected result st=%0d pid=%0d occ=%0d hits=%0d", $time,
                 status, pattern_id, occurrences, matches_here);
        errors++;
      end else begin
        e = pending.pop_front();
        if (status !== e.st) begin
          $display("%0t: status exp %0d got %0d", $time, e.st, status);
          errors++;
        end
        if (pattern_id !== e.pid) begin
          $display("%0t: pattern_id exp %0d got %0d", $time, e.pid, pattern_id);
          errors++;
        end
        if (occurrences !== e.occ) begin
          $display("%0t: occurrences exp %0d got %0d", $time, e.occ, occurrences);
          errors++;
        end
        if (matches_here !== e.hits) begin
          $display("%0t: matches_here exp %0d got %0d", $time, e.hits, matches_here);
          errors++;
        end
      end
    end
  end

  // Edge cases before any pattern, empty and duplicate patterns, byte extremes
  task automatic test_directed_load();
    send_word(OP_READ, 8'h00, 8'd0);
    send_word(OP_SCAN, 8'h61, 8'd0);
    send_word(3'd5, 8'h00, 8'd0);
    send_word(3'd6, 8'hff, 8'hff);
    send_word(3'd7, 8'h5a, 8'ha5);
    send_word(OP_END, 8'h00, 8'd0);
    send_word(OP_APPEND, 8'h00, 8'd0);
    send_word(OP_APPEND, 8'hff, 8'd0);
    send_word(OP_END, 8'h00, 8'd0);
    send_word(OP_APPEND, 8'h00, 8'd0);
    send_word(OP_APPEND, 8'hff, 8'd0);
    send_word(OP_END, 8'h00, 8'd0);
    send_word(OP_APPEND, 8'h61, 8'd0);
    send_word(OP_APPEND, 8'h62, 8'd0);
    send_word(OP_END, 8'h00, 8'd0);
    send_word(OP_READ, 8'h00, 8'd0);
    send_word(OP_READ, 8'h00, 8'hff);
    send_word(OP_APPEND, 8'h62, 8'd0);
    send_word(OP_END, 8'h00, 8'd0);
  endtask

  // Random patterns until node and pattern tables both overflow
  task automatic test_random_load();
    int len;
    while (nodes_used < MAX_NODES) begin
      len = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
      for (int k = 0; k < len; k++) send_word(OP_APPEND, text_byte(), 8'($urandom));
      if ($urandom_range(19) == 0) send_word(OP_READ, 8'($urandom), 8'($urandom));
      if ($urandom_range(39) == 0) send_word(OP_SCAN, 8'($urandom), 8'($urandom));
      if ($urandom_range(39) == 0) send_word(unused_op(), 8'($urandom), 8'($urandom));
      send_word(OP_END, 8'($urandom), 8'($urandom));
    end
    for (int k = 0; k < 4; k++) send_word(OP_APPEND, 8'($urandom), 8'd0);
    while (pats_used < MAX_PATTERNS) send_word(OP_END, 8'd0, 8'd0);
    for (int k = 0; k < 3; k++) send_word(OP_END, 8'd0, 8'd0);
  endtask

  // Build once, then check that loading and a second build are refused
  task automatic test_build();
    send_word(OP_BUILD, 8'($urandom), 8'($urandom));
    send_word(OP_BUILD, 8'($urandom), 8'($urandom));
    send_word(OP_APPEND, 8'h61, 8'd0);
    send_word(OP_END, 8'h00, 8'd0);
  endtask

  // Text scanning mixed with count reads and refused words
  task automatic test_random_scan();
    int pick;
    for (int k = 0; k < 300; k++) begin
      pick = $urandom_range(99);
      if (pick < 70) send_word(OP_SCAN, text_byte(), 8'($urandom));
      else if (pick < 90) send_word(OP_READ, 8'($urandom), 8'($urandom));
      else if (pick < 94) send_word(unused_op(), 8'($urandom), 8'($urandom));
      else send_word(OP_SSEL(pick), 8'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    operation = OP_APPEND;
    symbol = '0;
    pattern_index = '0;
    for (int i = 0; i < MAX_NODES*ALPHA_SIZE; i++) kid[i] = '0;
    for (int i = 0; i < MAX_NODES; i++) begin
      fail_of[i] = '0;
      dict_of[i] = '0;
      term[i] = 0;
      hit_cnt[i] = '0;
    end
    nodes_used = 1;
    pats_used = 0;
    ins_node = '0;
    cur_node = '0;
    built = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_load();
    test_random_load();
    test_build();
    test_random_scan();
    start <= 1'b0;
    while (pending.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

  // Run limit: reset sweep, a full-trie build and all words, with wide margin
  initial begin
    #(4 * 4000000);
    $display("testbench: errors");
    $finish;
  end

endmodule

// ----- multi_pattern_string_matcher_core.f -----
sv/amc_pkg.sv
sv/amc_ram.sv
sv/multi_pattern_string_matcher_core.sv
bench/testbench.sv
